>>> design/u8cjk_pkg.sv
// Package: shared types and constants for the UTF-8 decoder with CJK detection.
package u8cjk_pkg;

   localparam int unsigned CpWidth   = 21;
   localparam int unsigned ResMax    = 4;
   localparam int unsigned QueueDepth = 5;

   // One decoded result as it sits in the output queue.
   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               well_formed;
      logic               is_cjk;
      logic               text_has_cjk;
      logic               run_end;
      logic               text_end;
   } result_type;

   // Code point ranges that count as CJK ideographs.
   function automatic logic in_cjk(input logic [CpWidth-1:0] cp);
      in_cjk = (cp >= 21'h03400 && cp <= 21'h04DBF) ||
               (cp >= 21'h04E00 && cp <= 21'h09FFF) ||
               (cp >= 21'h0F900 && cp <= 21'h0FAFF) ||
               (cp >= 21'h20000 && cp <= 21'h2A6DF) ||
               (cp >= 21'h2A700 && cp <= 21'h2B73F) ||
               (cp >= 21'h2B740 && cp <= 21'h2B81F) ||
               (cp >= 21'h2B820 && cp <= 21'h2CEAF);
   endfunction

endpackage

>>> design/utf8_decode_cjk_detect.sv
// Top level: streaming lenient UTF-8 decoder with CJK range detection.
//
// The req_ channel carries one byte of text per transfer, with req_last_byte
// set on the final byte. The rsp_ channel carries one code point per transfer
// with its well-formed, CJK and sticky text CJK flags; rsp_run_end marks the
// last result caused by an input byte and rsp_text_end the last one of a text.
// A byte that only extends a pending sequence produces no result.
// Each accepted byte is decoded in the cycle it is taken and its 0 to 4
// results are written into a five-entry output queue, whose registered head
// entry drives the rsp_ ports. Throughput is one byte per cycle while each
// byte yields at most one result and the receiver does not hold rsp_stall.
// The queue drains one result per cycle while rsp_stall is low; req_stall is
// high while it holds more than one result, so a broken sequence that flushes
// raw bytes holds off the input until the queue is down to one result.
// When the receiver holds rsp_stall, the head result stays on the rsp_ ports
// and the input stalls once the queue holds two results.
// Synchronous reset empties the queue and clears the pending sequence and
// the sticky CJK flag.
module utf8_decode_cjk_detect (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [20:0] rsp_code_point,
   output logic        rsp_well_formed,
   output logic        rsp_is_cjk,
   output logic        rsp_text_has_cjk,
   output logic        rsp_run_end,
   output logic        rsp_text_end
);

   localparam int unsigned Depth = u8cjk_pkg::QueueDepth;

   // Decoder state.
   logic [7:0] lead_held_ff, lead_held_in;
   logic [7:0] cont_held_ff [2];
   logic [1:0] cont_seen_ff, cont_seen_in;
   logic [1:0] cont_needed_ff, cont_needed_in;
   logic       cjk_seen_ff, cjk_seen_in;

   // Output queue.
   u8cjk_pkg::result_type queue_ff [Depth];
   u8cjk_pkg::result_type queue_in [Depth];
   logic [2:0] count_ff, count_in;

   logic push, pop;
   logic [7:0] b;
   logic is_cont, pending, complete, store, brk, flush_en, fresh_en, fresh_emit, hold;
   logic [1:0] lead_need, fseen;
   logic [7:0] h0, h1;
   logic [20:0] full_cp;
   logic full_cjk;
   u8cjk_pkg::result_type res [u8cjk_pkg::ResMax];
   logic [2:0] n_res, base;
   u8cjk_pkg::result_type shifted [Depth];

   assign b         = req_data_byte;
   assign req_stall = count_ff > 3'd1;
   assign push      = req_valid && !req_stall;
   assign rsp_valid = count_ff != 3'd0;
   assign pop       = rsp_valid && !rsp_stall;

   assign rsp_code_point   = queue_ff[0].code_point;
   assign rsp_well_formed  = queue_ff[0].well_formed;
   assign rsp_is_cjk       = queue_ff[0].is_cjk;
   assign rsp_text_has_cjk = queue_ff[0].text_has_cjk;
   assign rsp_run_end      = queue_ff[0].run_end;
   assign rsp_text_end     = queue_ff[0].text_end;

   always_comb begin
      priority if (b[7:5] == 3'b110) begin
         lead_need = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
         lead_need = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
         lead_need = 2'd3;
      end else begin
         lead_need = 2'd0;
      end
   end

   assign is_cont    = b[7:6] == 2'b10;
   assign pending    = cont_needed_ff != 2'd0;
   assign complete   = pending && is_cont &&
                       (({1'b0, cont_seen_ff} + 3'd1) >= {1'b0, cont_needed_ff});
   assign store      = pending && is_cont && !complete;
   assign brk        = pending && !is_cont;
   assign flush_en   = brk || (store && req_last_byte);
   assign fresh_en   = !pending || brk;
   assign fresh_emit = fresh_en && (!b[7] || lead_need == 2'd0 || req_last_byte);
   assign hold       = fresh_en && b[7] && lead_need != 2'd0 && !req_last_byte;

   // Held continuation bytes as they stand after this byte is stored.
   assign h0    = (store && cont_seen_ff == 2'd0) ? b : cont_held_ff[0];
   assign h1    = (store && cont_seen_ff == 2'd1) ? b : cont_held_ff[1];
   assign fseen = brk ? cont_seen_ff : cont_seen_ff + 2'd1;

   always_comb begin
      unique case (cont_needed_ff)
         2'd1:    full_cp = {10'd0, lead_held_ff[4:0], b[5:0]};
         2'd2:    full_cp = {5'd0, lead_held_ff[3:0], cont_held_ff[0][5:0], b[5:0]};
         default: full_cp = {lead_held_ff[2:0], cont_held_ff[0][5:0],
                             cont_held_ff[1][5:0], b[5:0]};
      endcase
   end

   assign full_cjk = u8cjk_pkg::in_cjk(full_cp);

   // Build the results of this byte in order. Raw bytes are never CJK, so
   // only a completed sequence can set the sticky flag.
   always_comb begin
      logic [2:0] nf;
      nf = 3'd0;
      for (int k = 0; k < u8cjk_pkg::ResMax; k++) begin
         res[k] = '0;
         res[k].text_has_cjk = cjk_seen_ff;
      end
      if (complete) begin
         res[0].code_point   = full_cp;
         res[0].well_formed  = 1'b1;
         res[0].is_cjk       = full_cjk;
         res[0].text_has_cjk = cjk_seen_ff | full_cjk;
         nf = 3'd1;
      end else begin
         if (flush_en) begin
            res[0].code_point = {13'd0, lead_held_ff};
            res[1].code_point = {13'd0, h0};
            res[2].code_point = {13'd0, h1};
            nf = 3'd1 + {1'b0, fseen};
         end
         if (fresh_emit) begin
            for (int k = 0; k < u8cjk_pkg::ResMax; k++) begin
               if (nf == 3'(k)) begin
                  res[k].code_point  = {13'd0, b};
                  res[k].well_formed = !b[7];
               end
            end
            nf = nf + 3'd1;
         end
      end
      for (int k = 0; k < u8cjk_pkg::ResMax; k++) begin
         if (nf == 3'(k + 1)) begin
            res[k].run_end  = 1'b1;
            res[k].text_end = req_last_byte;
         end
      end
      n_res = nf;
   end

   // Next decoder state.
   always_comb begin
      lead_held_in   = lead_held_ff;
      cont_seen_in   = cont_seen_ff;
      cont_needed_in = cont_needed_ff;
      cjk_seen_in    = cjk_seen_ff;
      if (push) begin
         if (complete || brk) begin
            lead_held_in   = 8'd0;
            cont_seen_in   = 2'd0;
            cont_needed_in = 2'd0;
            cjk_seen_in    = cjk_seen_ff | (complete && full_cjk);
         end else if (store) begin
            cont_seen_in = cont_seen_ff + 2'd1;
         end
         if (hold) begin
            lead_held_in   = b;
            cont_seen_in   = 2'd0;
            cont_needed_in = lead_need;
         end
         if (req_last_byte) begin
            lead_held_in   = 8'd0;
            cont_seen_in   = 2'd0;
            cont_needed_in = 2'd0;
            cjk_seen_in    = 1'b0;
         end
      end
   end

   // Queue: shift out the head on a transfer, then append new results.
   assign base = count_ff - {2'd0, pop};

   always_comb begin
      for (int i = 0; i < Depth; i++) begin
         if (pop && i < Depth - 1) begin
            shifted[i] = queue_ff[i + 1];
         end else begin
            shifted[i] = queue_ff[i];
         end
      end
      for (int i = 0; i < Depth; i++) begin
         queue_in[i] = shifted[i];
         for (int k = 0; k < u8cjk_pkg::ResMax; k++) begin
            if (push && 3'(k) < n_res && (base + 3'(k)) == 3'(i)) begin
               queue_in[i] = res[k];
            end
         end
      end
      count_in = base + (push ? n_res : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= 3'd0;
         lead_held_ff   <= 8'd0;
         cont_seen_ff   <= 2'd0;
         cont_needed_ff <= 2'd0;
         cjk_seen_ff    <= 1'b0;
      end else begin
         count_ff       <= count_in;
         lead_held_ff   <= lead_held_in;
         cont_seen_ff   <= cont_seen_in;
         cont_needed_ff <= cont_needed_in;
         cjk_seen_ff    <= cjk_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < Depth; i++) begin
         queue_ff[i] <= queue_in[i];
      end
      if (push && store) begin
         cont_held_ff[cont_seen_ff[0]] <= b;
      end
   end

endmodule
